FILE: sv/nba_pkg.sv
package nba_pkg;

  localparam int MAP_BITS = 4096;
  localparam int ROW_BITS = 64;
  localparam int ROWS     = MAP_BITS / ROW_BITS;
  localparam int IDX_W    = $clog2(MAP_BITS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int COL_W    = $clog2(ROW_BITS);
  localparam int ROW_W    = IDX_W - COL_W;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EXAM,
    S_DONE
  } state_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // lowest set bit of a row word
  function automatic logic [COL_W-1:0] first_one(input logic [ROW_BITS-1:0] v);
    logic [COL_W-1:0] pos;
    pos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) pos = COL_W'(i);
    end
    return pos;
  endfunction

endpackage

FILE: sv/nba_ram.sv
module nba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/node_bitmap_allocator.sv
// a free goes from the accepted word through the row read and one examine step to the result
//   word; an allocate scans from row 0, one 64-node row per cycle, until it finds a free node
//   or reaches the last valid row (1..64 rows); the request rate is bounded by this scan of the
//   bitmap ram; a new request is taken while the previous result waits downstream
// reset: the node total returns to 4096 and the per-row valid flags clear at once, so the
//   bitmap reads as all free except node 0 with no clearing pass
module node_bitmap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // node_index[11:0], zero fill
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // status[1:0], allocated_index[13:2], free_count[26:14]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data   // node total
);
  import nba_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] node_total;
  logic [CNT_W-1:0] used_count;
  logic             kind;
  logic [IDX_W-1:0] idx;
  logic [ROW_W-1:0] row;
  logic [ROWS-1:0]  row_valid;
  status_t          res_status;
  logic [IDX_W-1:0] res_alloc;

  logic                mem_we;
  logic [ROW_W-1:0]    mem_raddr;
  logic [ROW_BITS-1:0] mem_wdata;
  logic [ROW_BITS-1:0] mem_rdata;

  logic [CNT_W-1:0]    eff;
  logic [CNT_W-1:0]    last;
  logic [ROW_W-1:0]    last_row;
  logic [COL_W-1:0]    last_col;
  logic [ROW_BITS-1:0] word;
  logic [ROW_BITS-1:0] lim_mask;
  logic [ROW_BITS-1:0] cand;
  logic                found;
  logic [COL_W-1:0]    pos;
  logic [COL_W-1:0]    col;
  logic                free_bad;
  logic                exam_done;
  logic                out_free;
  logic [CNT_W-1:0]    free_count;

  nba_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (row),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // node total clamped to 1..MAP_BITS
  always_comb begin
    if (node_total == '0) eff = CNT_W'(1);
    else if (node_total > CNT_W'(MAP_BITS)) eff = CNT_W'(MAP_BITS);
    else eff = node_total;
  end

  assign last     = eff - CNT_W'(1);
  assign last_row = last[IDX_W-1:COL_W];
  assign last_col = last[COL_W-1:0];

  // rows never written read as reset contents: only node 0 used
  always_comb begin
    if (row_valid[row]) word = mem_rdata;
    else if (row == '0) word = ROW_BITS'(1);
    else word = '0;
  end

  assign lim_mask = (row != last_row) ? '1 : ({ROW_BITS{1'b1}} >> (COL_W'(ROW_BITS - 1) - last_col));
  assign cand     = ~word & lim_mask;
  assign found    = |cand;
  assign pos      = first_one(cand);
  assign col      = idx[COL_W-1:0];
  assign free_bad = (idx == '0) || ({1'b0, idx} >= eff);
  assign exam_done = (kind == KIND_FREE) || found || (row == last_row);
  assign out_free  = !m_tvalid || m_tready;
  assign free_count = (used_count >= eff) ? '0 : eff - used_count;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_RD;
      S_RD:   state_next = S_EXAM;
      S_EXAM: if (exam_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    cfg_ready = 1'b1;
    mem_raddr = row;
    mem_we    = 1'b0;
    mem_wdata = word;
    unique case (state)
      S_EXAM: begin
        // fetch the next row ahead while this one is examined
        mem_raddr = row + ROW_W'(1);
        if (kind == KIND_ALLOC) begin
          mem_we    = found;
          mem_wdata = word | (ROW_BITS'(1) << pos);
        end else begin
          mem_we    = !free_bad && word[col];
          mem_wdata = word & ~(ROW_BITS'(1) << col);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_total <= CNT_W'(MAP_BITS);
      used_count <= CNT_W'(1);
      row_valid  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) node_total <= cfg_data;
      if (mem_we) row_valid[row] <= 1'b1;
      if (state == S_EXAM && exam_done) begin
        if (kind == KIND_ALLOC && found) used_count <= used_count + CNT_W'(1);
        if (kind == KIND_FREE && mem_we) used_count <= used_count - CNT_W'(1);
      end
      if (state == S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      kind <= s_tuser;
      idx  <= s_tdata[IDX_W-1:0];
      row  <= (s_tuser == KIND_FREE) ? s_tdata[IDX_W-1:COL_W] : '0;
    end
    if (state == S_EXAM) begin
      if (!exam_done) row <= row + ROW_W'(1);
      if (kind == KIND_ALLOC) begin
        if (found) begin
          res_status <= ST_OK;
          res_alloc  <= {row, pos};
        end else begin
          res_status <= ST_FULL;
          res_alloc  <= '0;
        end
      end else begin
        res_alloc <= '0;
        if (free_bad) begin
          res_status <= ST_INVALID;
        end else if (!word[col]) begin
          res_status <= ST_DOUBLE;
        end else begin
          res_status <= ST_OK;
        end
      end
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {5'b0, free_count, res_alloc, res_status};
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(MAP_BITS))
    else $error("used count above map size");

  a_we_in_exam: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_EXAM)
    else $error("bitmap write outside examine state");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXAM && kind == KIND_ALLOC) |-> row <= last_row)
    else $error("allocate scan ran past last valid row");

  a_alloc_one_bit: assert property (@(posedge clk) disable iff (rst)
    (mem_we && kind == KIND_ALLOC) |-> $countones(mem_wdata) == $countones(word) + 1)
    else $error("allocate write did not set exactly one bit");

  a_free_one_bit: assert property (@(posedge clk) disable iff (rst)
    (mem_we && kind == KIND_FREE) |-> $countones(mem_wdata) + 1 == $countones(word))
    else $error("free write did not clear exactly one bit");

endmodule
